FILE: src/sde_pkg.sv
// shared types and constants of the string dictionary encoder
`default_nettype none

package sde_pkg;

   localparam int DEFAULT_TABLE_DEPTH   = 1024;
   localparam int DEFAULT_MAX_VALUE_LEN = 32;

   localparam int BYTE_W   = 8;
   localparam int KEY_W    = 10;
   localparam int LIMIT_W  = 11;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

   typedef enum logic [1:0] {
      ST_FOUND    = 2'd0,
      ST_INSERTED = 2'd1,
      ST_FULL     = 2'd2,
      ST_TOO_LONG = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_COLLECT,
      S_LEN_RD,
      S_LEN_CHK,
      S_BYTE_CHK,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] value_byte;
      logic              last_byte;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0] key_index;
      status_type       status;
   } rsp_type;

endpackage

`default_nettype wire

FILE: src/string_dictionary_encoder_core.sv
// string dictionary encoder: byte collection, table search and insert
//
//  channel  direction  handshake           payload
//  req      in         req_valid/req_stall  sde_pkg::req_type (value_byte, last_byte)
//  rsp      out        rsp_valid/rsp_stall  sde_pkg::rsp_type (key_index, status)
//  csr      in         csr_wr_en            csr_wr_data = table_limit
//
// the last byte starts the search: an entry of other length is passed after its length
// check, one of equal length is compared byte by byte, a miss runs past the last entry,
// and an overlong value skips the search; the result is handed off once the rsp register
// is free. the value is written straight into the next free row, so an insert costs no
// copy. synchronous reset empties the table through the entry count. a waiting result in
// the rsp register does not block new bytes.
`default_nettype none

module string_dictionary_encoder_core #(
   parameter int TABLE_DEPTH   = sde_pkg::DEFAULT_TABLE_DEPTH,
   parameter int MAX_VALUE_LEN = sde_pkg::DEFAULT_MAX_VALUE_LEN
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire sde_pkg::req_type             req_payload,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output sde_pkg::rsp_type                  rsp_payload,
   input  wire logic                         csr_wr_en,
   input  wire logic [sde_pkg::LIMIT_W-1:0]  csr_wr_data
);

   localparam int ROW_W   = $clog2(TABLE_DEPTH + 1);
   localparam int LADDR_W = $clog2(TABLE_DEPTH);
   localparam int LEN_W   = $clog2(MAX_VALUE_LEN + 1);
   localparam int POS_W   = $clog2(MAX_VALUE_LEN);
   localparam int BDEPTH  = (TABLE_DEPTH + 1) * MAX_VALUE_LEN;
   localparam int BADDR_W = $clog2(BDEPTH);
   localparam int CMP_W   = (ROW_W > sde_pkg::LIMIT_W) ? ROW_W : sde_pkg::LIMIT_W;
   localparam int KEXT_W  = (ROW_W > sde_pkg::KEY_W) ? ROW_W : sde_pkg::KEY_W;

   sde_pkg::state_type             state_ff, state_in;
   logic [sde_pkg::LIMIT_W-1:0]    limit_ff;
   logic [LEN_W-1:0]               len_ff, len_in;
   logic                           overlong_ff, overlong_in;
   logic [ROW_W-1:0]               count_ff, count_in;
   logic [ROW_W-1:0]               idx_ff, idx_in;
   logic [POS_W-1:0]               pos_ff, pos_in;
   logic [ROW_W-1:0]               res_index_ff, res_index_in;
   sde_pkg::status_type            res_status_ff, res_status_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   sde_pkg::rsp_type               rsp_payload_ff, rsp_payload_in;

   logic                           req_accept;
   logic                           rsp_free;
   logic                           rsp_load;
   logic                           len_full;
   logic                           overlong_now;
   logic                           table_full;
   logic                           len_match;
   logic                           byte_match;
   logic                           pos_last;
   logic [POS_W-1:0]               rd_pos;
   logic [KEXT_W-1:0]              res_index_ext;

   logic                           byte_wr_en;
   logic [BADDR_W-1:0]             byte_wr_addr;
   logic [BADDR_W-1:0]             byte_rd_addr_a;
   logic [BADDR_W-1:0]             byte_rd_addr_b;
   logic [sde_pkg::BYTE_W-1:0]     entry_byte;
   logic [sde_pkg::BYTE_W-1:0]     value_byte_rd;

   logic                           len_wr_en;
   logic [LADDR_W-1:0]             len_rd_addr;
   logic [LEN_W-1:0]               entry_len;

   // entry rows, plus one spare row so the incoming value always has a place
   sde_ram #(
      .WIDTH (sde_pkg::BYTE_W),
      .DEPTH (BDEPTH)
   ) u_byte_ram (
      .clock     (clock),
      .wr_en     (byte_wr_en),
      .wr_addr   (byte_wr_addr),
      .wr_data   (req_payload.value_byte),
      .rd_addr_a (byte_rd_addr_a),
      .rd_data_a (entry_byte),
      .rd_addr_b (byte_rd_addr_b),
      .rd_data_b (value_byte_rd)
   );

   sde_ram #(
      .WIDTH (LEN_W),
      .DEPTH (TABLE_DEPTH)
   ) u_len_ram (
      .clock     (clock),
      .wr_en     (len_wr_en),
      .wr_addr   (count_ff[LADDR_W-1:0]),
      .wr_data   (len_ff),
      .rd_addr_a (len_rd_addr),
      .rd_data_a (entry_len),
      .rd_addr_b (len_rd_addr),
      .rd_data_b ()
   );

   assign req_accept   = req_valid && !req_stall;
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign len_full     = (len_ff == LEN_W'(MAX_VALUE_LEN));
   assign overlong_now = overlong_ff || len_full;
   assign table_full   = (CMP_W'(count_ff) >= CMP_W'(limit_ff))
                         || (count_ff == ROW_W'(TABLE_DEPTH));
   assign len_match    = (entry_len == len_ff);
   assign byte_match   = (entry_byte == value_byte_rd);
   assign pos_last     = ((LEN_W'(pos_ff) + LEN_W'(1)) == len_ff);
   assign len_rd_addr  = idx_ff[LADDR_W-1:0];
   assign res_index_ext = KEXT_W'(res_index_ff);

   // byte reads: first byte of a row right after the length check, then the next one
   assign rd_pos = (state_ff == sde_pkg::S_LEN_CHK) ? '0 : pos_ff + POS_W'(1);
   assign byte_rd_addr_a = BADDR_W'(idx_ff) * BADDR_W'(MAX_VALUE_LEN) + BADDR_W'(rd_pos);
   assign byte_rd_addr_b = BADDR_W'(count_ff) * BADDR_W'(MAX_VALUE_LEN) + BADDR_W'(rd_pos);
   assign byte_wr_addr   = BADDR_W'(count_ff) * BADDR_W'(MAX_VALUE_LEN)
                           + BADDR_W'(len_ff[POS_W-1:0]);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sde_pkg::S_COLLECT: begin
            if (req_accept && req_payload.last_byte) begin
               state_in = overlong_now ? sde_pkg::S_FINISH : sde_pkg::S_LEN_RD;
            end
         end
         sde_pkg::S_LEN_RD: begin
            state_in = (idx_ff == count_ff) ? sde_pkg::S_FINISH : sde_pkg::S_LEN_CHK;
         end
         sde_pkg::S_LEN_CHK: begin
            state_in = len_match ? sde_pkg::S_BYTE_CHK : sde_pkg::S_LEN_RD;
         end
         sde_pkg::S_BYTE_CHK: begin
            if (!byte_match) begin
               state_in = sde_pkg::S_LEN_RD;
            end else if (pos_last) begin
               state_in = sde_pkg::S_FINISH;
            end
         end
         sde_pkg::S_FINISH: begin
            if (rsp_free) begin
               state_in = sde_pkg::S_COLLECT;
            end
         end
         default: state_in = sde_pkg::S_COLLECT;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_stall      = 1'b1;
      rsp_load       = 1'b0;
      byte_wr_en     = 1'b0;
      len_wr_en      = 1'b0;
      len_in         = len_ff;
      overlong_in    = overlong_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      pos_in         = pos_ff;
      res_index_in   = res_index_ff;
      res_status_in  = res_status_ff;
      unique case (state_ff)
         sde_pkg::S_COLLECT: begin
            req_stall = 1'b0;
            if (req_accept) begin
               if (!len_full) begin
                  byte_wr_en = 1'b1;
                  len_in     = len_ff + LEN_W'(1);
               end else begin
                  overlong_in = 1'b1;
               end
               if (req_payload.last_byte) begin
                  idx_in        = '0;
                  res_index_in  = '0;
                  res_status_in = sde_pkg::ST_TOO_LONG;
               end
            end
         end
         sde_pkg::S_LEN_RD: begin
            // whole table searched without a match
            if (idx_ff == count_ff) begin
               if (table_full) begin
                  res_index_in  = '0;
                  res_status_in = sde_pkg::ST_FULL;
               end else begin
                  len_wr_en     = 1'b1;
                  count_in      = count_ff + ROW_W'(1);
                  res_index_in  = count_ff;
                  res_status_in = sde_pkg::ST_INSERTED;
               end
            end
         end
         sde_pkg::S_LEN_CHK: begin
            pos_in = '0;
            if (!len_match) begin
               idx_in = idx_ff + ROW_W'(1);
            end
         end
         sde_pkg::S_BYTE_CHK: begin
            if (!byte_match) begin
               idx_in = idx_ff + ROW_W'(1);
            end else if (pos_last) begin
               res_index_in  = idx_ff;
               res_status_in = sde_pkg::ST_FOUND;
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
         sde_pkg::S_FINISH: begin
            if (rsp_free) begin
               rsp_load    = 1'b1;
               len_in      = '0;
               overlong_in = 1'b0;
            end
         end
         default: req_stall = 1'b1;
      endcase
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (rsp_load) begin
         rsp_valid_in             = 1'b1;
         rsp_payload_in.key_index = res_index_ext[sde_pkg::KEY_W-1:0];
         rsp_payload_in.status    = res_status_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sde_pkg::S_COLLECT;
         limit_ff     <= sde_pkg::LIMIT_RESET;
         len_ff       <= '0;
         overlong_ff  <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         overlong_ff  <= overlong_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      pos_ff         <= pos_in;
      res_index_ff   <= res_index_in;
      res_status_ff  <= res_status_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ROW_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_found_stored: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sde_pkg::S_FINISH && res_status_ff == sde_pkg::ST_FOUND)
      |-> res_index_ff < count_ff)
      else $error("found index is not a stored entry");

   a_insert_counted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sde_pkg::S_FINISH && res_status_ff == sde_pkg::ST_INSERTED)
      |-> count_ff == res_index_ff + ROW_W'(1))
      else $error("inserted index does not match entry count");

   a_search_value: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sde_pkg::S_LEN_RD || state_ff == sde_pkg::S_LEN_CHK
       || state_ff == sde_pkg::S_BYTE_CHK) |-> (len_ff != '0 && !overlong_ff))
      else $error("search running on an empty or overlong value");

   a_error_key_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_payload_ff.status == sde_pkg::ST_FULL
                        || rsp_payload_ff.status == sde_pkg::ST_TOO_LONG))
      |-> rsp_payload_ff.key_index == '0)
      else $error("error request carries a nonzero key");

endmodule

`default_nettype wire

FILE: src/sde_ram.sv
// generic synchronous ram: one write port, two registered read ports
`default_nettype none

module sde_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr_a,
   output logic      [WIDTH-1:0]  rd_data_a,
   input  wire logic [ADDR_W-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

`default_nettype wire
